// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/core/mwo_pkg.sv
// Types, constants and arithmetic helpers of the mecanum odometry block
package mwo_pkg;

    localparam int POS_W      = 32;
    localparam int STAMP_W    = 48;
    localparam int SEP_W      = 31;
    localparam int WIN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int DLT_W      = 33;
    localparam int SUMD_W     = 35;
    localparam int DIV_W      = 51;
    localparam int DVS_W      = 48;
    localparam int PROD_W     = 54;

    localparam logic [CFG_IDX_W-1:0] CFG_SEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN = 2'd1;

    localparam logic [21:0] US_PER_S = 22'd1000000;

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_INIT   = 2'd1,
        ACT_ZERO   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        DSEL_ROT  = 2'd0,
        DSEL_RATE = 2'd1,
        DSEL_MEAN = 2'd2
    } dsel_t;

    typedef struct packed {
        logic       latch;
        logic       init;
        logic       zero_pose;
        logic       reject;
        logic       delta;
        logic       term;
        logic       div_start;
        dsel_t      dsel;
        logic       rot_done;
        logic       pose;
        logic       rate_mul;
        logic       rate_done;
        logic       ring;
        logic       push;
        logic       mean_done;
        logic [1:0] chan;
        logic       load_out;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    interval_ok;
        logic    div_done;
        logic    div_busy;
        logic    out_free;
    } dp_stat_t;

    // signed 35-bit divided by four, truncating toward zero
    function automatic logic signed [SUMD_W-1:0] quarter(input logic signed [SUMD_W-1:0] v);
        logic signed [SUMD_W-1:0] b;
        b = v + (v[SUMD_W-1] ? SUMD_W'(3) : SUMD_W'(0));
        return b >>> 2;
    endfunction

    function automatic logic signed [31:0] sat35(input logic signed [SUMD_W-1:0] v);
        if (v > SUMD_W'(signed'(32'sh7FFFFFFF)))
            return 32'sh7FFFFFFF;
        else if (v < SUMD_W'(signed'(32'sh80000000)))
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            return v[31:0];
    endfunction

    // apply sign to a quotient magnitude and saturate to 32-bit signed
    function automatic logic signed [31:0] sat_q(input logic neg, input logic [DIV_W-1:0] q);
        if (neg)
            return (q > DIV_W'(33'h080000000)) ? 32'sh80000000 : -q[31:0];
        else
            return (q > DIV_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : q[31:0];
    endfunction

endpackage

// File: rtl/core/mwo_if.sv
// Handshake channels: update items in, odometry results out
interface mwo_upd_if import mwo_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] front_left_pos;
    logic signed [31:0] front_right_pos;
    logic signed [31:0] back_left_pos;
    logic signed [31:0] back_right_pos;
    logic [47:0]        stamp_us;

    modport source (output valid, action, front_left_pos, front_right_pos,
                    back_left_pos, back_right_pos, stamp_us, input ready);
    modport sink   (input valid, action, front_left_pos, front_right_pos,
                    back_left_pos, back_right_pos, stamp_us, output ready);
endinterface

interface mwo_res_if import mwo_pkg::*;;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic signed [31:0] mean_vel_x;
    logic signed [31:0] mean_vel_y;
    logic signed [31:0] mean_turn_rate;

    modport source (output valid, accepted, pose_x, pose_y, pose_heading,
                    mean_vel_x, mean_vel_y, mean_turn_rate, input ready);
    modport sink   (input valid, accepted, pose_x, pose_y, pose_heading,
                    mean_vel_x, mean_vel_y, mean_turn_rate, output ready);
endinterface

// File: rtl/core/mwo_ram.sv
// Generic single-write, single-read RAM with registered read data
module mwo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mwo_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes
module mwo_div import mwo_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        ge       = rem_sh >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (start)
            dvs_reg <= divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/mwo_dp.sv
// Datapath: odometry state, kinematics, rate ring, divider and result register
module mwo_dp import mwo_pkg::*; #(
    parameter int WINDOW_MAX      = 64,
    parameter int MIN_INTERVAL_US = 100
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [1:0]            in_action,
    input  logic signed [31:0]    in_fl,
    input  logic signed [31:0]    in_fr,
    input  logic signed [31:0]    in_bl,
    input  logic signed [31:0]    in_br,
    input  logic [STAMP_W-1:0]    in_stamp,
    input  logic                  res_ready,
    output logic                  res_valid,
    output logic                  res_accepted,
    output logic signed [31:0]    res_pose_x,
    output logic signed [31:0]    res_pose_y,
    output logic signed [31:0]    res_pose_heading,
    output logic signed [31:0]    res_mean_x,
    output logic signed [31:0]    res_mean_y,
    output logic signed [31:0]    res_mean_turn
);

    localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = 33 + $clog2(WINDOW_MAX);
    localparam int DEPTH  = 3 * WINDOW_MAX;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int EW     = (FILL_W > WIN_W) ? FILL_W : WIN_W;

    // item
    action_t            act_reg;
    logic signed [31:0] pos_in_reg [4];
    logic [STAMP_W-1:0] stamp_in_reg;

    // odometry state
    logic signed [31:0]    prev_pos_reg [4];
    logic [STAMP_W-1:0]    prev_stamp_reg;
    logic signed [31:0]    pose_reg [3];
    logic signed [SUM_W-1:0] sum_reg [3];
    logic [PTR_W-1:0]      ptr_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [SEP_W-1:0]      sep_reg;
    logic [WIN_W-1:0]      win_reg;
    logic signed [31:0]    mean_reg [3];
    logic                  acc_reg;

    // work registers
    logic signed [DLT_W-1:0]  d_reg [4];
    logic [STAMP_W-1:0]       dt_reg;
    logic signed [31:0]       term_reg [3];
    logic signed [SUMD_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [31:0]       rate_reg;
    logic                     neg_reg;

    // result register
    logic               out_valid_reg;
    logic               out_acc_reg;
    logic signed [31:0] out_pose_reg [3];
    logic signed [31:0] out_mean_reg [3];

    logic signed [DLT_W-1:0]  d_c [4];
    logic [STAMP_W:0]         dt_full;
    logic signed [SUMD_W-1:0] e [4];
    logic signed [SUMD_W-1:0] s_fwd, s_side, s_rot;
    logic [EW-1:0]            win_ext, w_eff;
    logic                     full;
    logic [PTR_W-1:0]         p_eff, p_adv;
    logic [ADDR_W-1:0]        ring_addr;
    logic [31:0]              ring_rdata;
    logic [SEP_W-1:0]         k_eff;
    logic [SUMD_W-1:0]        mag_rot;
    logic [PROD_W-1:0]        mag_prod;
    logic signed [SUM_W-1:0]  sum_sel;
    logic [SUM_W-1:0]         mag_sum;
    logic [DIV_W-1:0]         div_a;
    logic [DVS_W-1:0]         div_b;
    logic                     div_neg;
    logic                     div_busy, div_done;
    logic [DIV_W-1:0]         div_q;
    logic signed [31:0]       q_sat;
    logic signed [SUM_W-1:0]  sum_ring;
    logic                     clear_means;
    logic                     out_free;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            d_c[i] = DLT_W'(pos_in_reg[i]) - DLT_W'(prev_pos_reg[i]);
            e[i]   = SUMD_W'(d_reg[i]);
        end
        dt_full = {1'b0, stamp_in_reg} - {1'b0, prev_stamp_reg};
        s_fwd  = e[0] + e[1] + e[2] + e[3];
        s_side = -e[0] + e[1] + e[2] - e[3];
        s_rot  = e[0] - e[1] + e[2] - e[3];
    end

    always_comb
    begin
        win_ext = EW'(win_reg);
        if (win_reg == '0)
            w_eff = EW'(1);
        else if (win_ext > EW'(WINDOW_MAX))
            w_eff = EW'(WINDOW_MAX);
        else
            w_eff = win_ext;
        full  = EW'(fill_reg) >= w_eff;
        p_eff = (EW'(ptr_reg) >= w_eff) ? '0 : ptr_reg;
        p_adv = (EW'(p_eff) + EW'(1) >= w_eff) ? '0 : p_eff + PTR_W'(1);
        ring_addr = ADDR_W'(cmd.chan) * ADDR_W'(WINDOW_MAX) + ADDR_W'(p_eff);
        k_eff = (sep_reg == '0) ? SEP_W'(1) : sep_reg;
    end

    // divider operand selection
    always_comb
    begin
        mag_rot  = diff_reg[SUMD_W-1] ? SUMD_W'(-diff_reg) : SUMD_W'(diff_reg);
        mag_prod = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        sum_sel  = sum_reg[cmd.chan];
        mag_sum  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
        unique case (cmd.dsel)
            DSEL_ROT:
            begin
                div_a   = {mag_rot, 16'b0};
                div_b   = DVS_W'({k_eff, 2'b00});
                div_neg = diff_reg[SUMD_W-1];
            end
            DSEL_RATE:
            begin
                div_a   = mag_prod[DIV_W-1:0];
                div_b   = dt_reg;
                div_neg = prod_reg[PROD_W-1];
            end
            DSEL_MEAN:
            begin
                div_a   = DIV_W'(mag_sum);
                div_b   = DVS_W'(fill_reg);
                div_neg = sum_sel[SUM_W-1];
            end
            default:
            begin
                div_a   = '0;
                div_b   = DVS_W'(1);
                div_neg = 1'b0;
            end
        endcase
    end

    mwo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    mwo_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.ring),
        .waddr (ring_addr),
        .wdata (rate_reg),
        .re    (cmd.rate_mul),
        .raddr (ring_addr),
        .rdata (ring_rdata)
    );

    assign q_sat    = sat_q(neg_reg, div_q);
    assign sum_ring = sum_reg[cmd.chan]
                    - (full ? SUM_W'(signed'(ring_rdata)) : SUM_W'(0))
                    + SUM_W'(rate_reg);
    assign clear_means = cmd.init || (cfg_we && cfg_index == CFG_WIN);
    assign out_free    = !out_valid_reg || res_ready;

    // item and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg       <= action_t'(in_action);
            pos_in_reg[0] <= in_fl;
            pos_in_reg[1] <= in_fr;
            pos_in_reg[2] <= in_bl;
            pos_in_reg[3] <= in_br;
            stamp_in_reg  <= in_stamp;
        end
        if (cmd.delta)
        begin
            for (int i = 0; i < 4; i++)
                d_reg[i] <= d_c[i];
            dt_reg <= dt_full[STAMP_W-1:0];
        end
        if (cmd.term)
        begin
            term_reg[0] <= sat35(quarter(s_fwd));
            term_reg[1] <= sat35(quarter(s_side));
            diff_reg    <= s_rot;
        end
        if (cmd.div_start)
            neg_reg <= div_neg;
        if (cmd.rot_done)
            term_reg[2] <= q_sat;
        if (cmd.rate_mul)
            prod_reg <= PROD_W'(term_reg[cmd.chan]) * PROD_W'(signed'({1'b0, US_PER_S}));
        if (cmd.rate_done)
            rate_reg <= q_sat;
        if (cmd.load_out)
        begin
            out_acc_reg <= acc_reg;
            for (int c = 0; c < 3; c++)
            begin
                out_pose_reg[c] <= pose_reg[c];
                out_mean_reg[c] <= mean_reg[c];
            end
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                prev_pos_reg[i] <= '0;
            for (int c = 0; c < 3; c++)
            begin
                pose_reg[c] <= '0;
                sum_reg[c]  <= '0;
                mean_reg[c] <= '0;
            end
            prev_stamp_reg <= '0;
            ptr_reg        <= '0;
            fill_reg       <= '0;
            sep_reg        <= SEP_W'(65536);
            win_reg        <= WIN_W'(10);
            acc_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_SEP)
                sep_reg <= cfg_data[SEP_W-1:0];
            if (cfg_we && cfg_index == CFG_WIN)
                win_reg <= cfg_data[WIN_W-1:0];
            if (clear_means)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sum_reg[c]  <= '0;
                    mean_reg[c] <= '0;
                end
                ptr_reg  <= '0;
                fill_reg <= '0;
            end
            if (cmd.init)
            begin
                prev_stamp_reg <= stamp_in_reg;
                acc_reg        <= 1'b1;
            end
            if (cmd.zero_pose)
            begin
                for (int c = 0; c < 3; c++)
                    pose_reg[c] <= '0;
                acc_reg <= 1'b1;
            end
            if (cmd.reject)
                acc_reg <= 1'b0;
            if (cmd.term)
            begin
                for (int i = 0; i < 4; i++)
                    prev_pos_reg[i] <= pos_in_reg[i];
                prev_stamp_reg <= stamp_in_reg;
                acc_reg        <= 1'b1;
            end
            if (cmd.pose)
                for (int c = 0; c < 3; c++)
                    pose_reg[c] <= sat33(33'(pose_reg[c]) + 33'(term_reg[c]));
            if (cmd.ring)
                sum_reg[cmd.chan] <= sum_ring;
            if (cmd.push)
            begin
                if (!full)
                    fill_reg <= fill_reg + FILL_W'(1);
                ptr_reg <= p_adv;
            end
            if (cmd.mean_done)
                mean_reg[cmd.chan] <= q_sat;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.action      = act_reg;
        stat.interval_ok = !dt_full[STAMP_W] && dt_full[STAMP_W-1:0] >= STAMP_W'(MIN_INTERVAL_US);
        stat.div_done    = div_done;
        stat.div_busy    = div_busy;
        stat.out_free    = out_free;
    end

    assign res_valid        = out_valid_reg;
    assign res_accepted     = out_acc_reg;
    assign res_pose_x       = out_pose_reg[0];
    assign res_pose_y       = out_pose_reg[1];
    assign res_pose_heading = out_pose_reg[2];
    assign res_mean_x       = out_mean_reg[0];
    assign res_mean_y       = out_mean_reg[1];
    assign res_mean_turn    = out_mean_reg[2];

endmodule

// File: rtl/core/mwo_ctrl.sv
// Controller: sequences one item through the datapath
module mwo_ctrl import mwo_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     upd_valid,
    output logic     upd_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [14:0] {
        ST_IDLE      = 15'b000000000000001,
        ST_DECODE    = 15'b000000000000010,
        ST_DELTA     = 15'b000000000000100,
        ST_TERM      = 15'b000000000001000,
        ST_ROT_GO    = 15'b000000000010000,
        ST_ROT_WAIT  = 15'b000000000100000,
        ST_POSE      = 15'b000000001000000,
        ST_MUL       = 15'b000000010000000,
        ST_RATE_GO   = 15'b000000100000000,
        ST_RATE_WAIT = 15'b000001000000000,
        ST_RING      = 15'b000010000000000,
        ST_PUSH      = 15'b000100000000000,
        ST_MEAN_GO   = 15'b001000000000000,
        ST_MEAN_WAIT = 15'b010000000000000,
        ST_OUT       = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] chan_reg, chan_next;

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cmd        = '0;
        cmd.chan   = chan_reg;
        cmd.dsel   = DSEL_ROT;
        upd_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                upd_ready = 1'b1;
                if (upd_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.action)
                    ACT_UPDATE: state_next = ST_DELTA;
                    ACT_INIT:
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_OUT;
                    end
                    ACT_ZERO:
                    begin
                        cmd.zero_pose = 1'b1;
                        state_next    = ST_OUT;
                    end
                    default:
                    begin
                        cmd.reject = 1'b1;
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_DELTA:
            begin
                cmd.delta = 1'b1;
                if (stat.interval_ok)
                    state_next = ST_TERM;
                else
                begin
                    cmd.reject = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = ST_ROT_GO;
            end
            ST_ROT_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_ROT_WAIT;
            end
            ST_ROT_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.rot_done = 1'b1;
                    state_next   = ST_POSE;
                end
            end
            ST_POSE:
            begin
                cmd.pose   = 1'b1;
                chan_next  = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.rate_mul = 1'b1;
                state_next   = ST_RATE_GO;
            end
            ST_RATE_GO:
            begin
                cmd.dsel      = DSEL_RATE;
                cmd.div_start = 1'b1;
                state_next    = ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.rate_done = 1'b1;
                    state_next    = ST_RING;
                end
            end
            ST_RING:
            begin
                cmd.ring = 1'b1;
                if (chan_reg == 2'd2)
                    state_next = ST_PUSH;
                else
                begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                chan_next  = 2'd0;
                state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO:
            begin
                cmd.dsel      = DSEL_MEAN;
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_done = 1'b1;
                    if (chan_reg == 2'd2)
                        state_next = ST_OUT;
                    else
                    begin
                        chan_next  = chan_reg + 2'd1;
                        state_next = ST_MEAN_GO;
                    end
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

endmodule

// File: rtl/core/mecanum_wheel_odometry.sv
// Top level: mecanum wheel odometry with rolling-mean rates
//
//  channel  dir  handshake      payload
//  upd      in   valid/ready    action, four wheel positions, stamp_us
//  res      out  valid/ready    accepted, pose x/y/heading, three mean rates
//  cfg      in   cfg_we         cfg_index, cfg_data (no read-back)
//
// An update item runs through one shared radix-2 divider of
// 51 quotient bits that serves the rotation term, three rates and three means.
// Init, zero-pose, rejected and unknown items do not use the divider.
// One item in flight; the next is taken while a result waits in the output register.
// Reset sets the separation to 65536 and the window to 10; the rate ring needs no clearing.
`include "assert_macros.svh"

module mecanum_wheel_odometry import mwo_pkg::*; #(
    parameter int WINDOW_MAX      = 64,
    parameter int MIN_INTERVAL_US = 100
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mwo_upd_if.sink               upd,
    mwo_res_if.source             res
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mwo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_valid (upd.valid),
        .upd_ready (upd.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mwo_dp #(
        .WINDOW_MAX      (WINDOW_MAX),
        .MIN_INTERVAL_US (MIN_INTERVAL_US)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .stat             (stat),
        .in_action        (upd.action),
        .in_fl            (upd.front_left_pos),
        .in_fr            (upd.front_right_pos),
        .in_bl            (upd.back_left_pos),
        .in_br            (upd.back_right_pos),
        .in_stamp         (upd.stamp_us),
        .res_ready        (res.ready),
        .res_valid        (res.valid),
        .res_accepted     (res.accepted),
        .res_pose_x       (res.pose_x),
        .res_pose_y       (res.pose_y),
        .res_pose_heading (res.pose_heading),
        .res_mean_x       (res.mean_vel_x),
        .res_mean_y       (res.mean_vel_y),
        .res_mean_turn    (res.mean_turn_rate)
    );

    `ASSERT_NEXT(a_one_item, clk, rst_n, upd.valid && upd.ready, !upd.ready)
    `ASSERT_IMPL(a_div_quiet, clk, rst_n, upd.ready, !stat.div_busy)
    `ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.load_out, !res.valid || res.ready)

endmodule

// File: tb/sv/mecanum_wheel_odometry_tb.sv
// Self-checking testbench of the mecanum wheel odometry block
`timescale 1ns / 100ps

module mecanum_wheel_odometry_tb;
    import mwo_pkg::*;

    typedef struct {
        action_t     act;
        logic [31:0] pos [4];
        logic [47:0] stamp;
    } odo_item_t;

    typedef struct {
        logic        accepted;
        logic [31:0] val [6];
    } odo_result_t;

    localparam int WIN_MAX  = 64;
    localparam int MIN_GAP  = 100;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mwo_upd_if upd ();
    mwo_res_if res ();

    mecanum_wheel_odometry #(
        .WINDOW_MAX      (WIN_MAX),
        .MIN_INTERVAL_US (MIN_GAP)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .upd       (upd),
        .res       (res)
    );

    odo_item_t   pending_items [$];
    odo_result_t expected_odo [$];
    int          error_count = 0;

    // predictor state
    longint sep_reg, win_reg;
    longint last_pos [4];
    longint last_stamp;
    longint pose [3];
    longint rate_hist [3][WIN_MAX];
    longint rate_total [3];
    int     hist_ptr, hist_fill;

    // stimulus side
    logic [47:0] gen_stamp;
    logic [31:0] gen_pos [4];
    bit          no_idle;
    int          hold_requests = 0;
    int          hold_served = 0;
    bit          upd_taken, res_taken;
    int          upd_gap, res_wait, hold_cnt;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic int window_size();
        if (win_reg < 1)
            return 1;
        if (win_reg > WIN_MAX)
            return WIN_MAX;
        return int'(win_reg);
    endfunction

    task automatic clear_rate_means();
        for (int c = 0; c < 3; c++)
            rate_total[c] = 0;
        hist_ptr = 0;
        hist_fill = 0;
    endtask

    task automatic predict_odometry(input odo_item_t it, output odo_result_t r);
        longint dt, k, cur;
        longint d [4];
        longint term [3];
        longint rate [3];
        int     w, p;
        r.accepted = 1'b0;
        if (it.act == ACT_UPDATE)
        begin
            if (longint'(it.stamp) >= last_stamp &&
                longint'(it.stamp) - last_stamp >= MIN_GAP)
            begin
                dt = longint'(it.stamp) - last_stamp;
                k = (sep_reg < 1) ? 1 : sep_reg;
                for (int i = 0; i < 4; i++)
                begin
                    cur = longint'($signed(it.pos[i]));
                    d[i] = cur - last_pos[i];
                    last_pos[i] = cur;
                end
                term[0] = sat_s32((d[0] + d[1] + d[2] + d[3]) / 4);
                term[1] = sat_s32((-d[0] + d[1] + d[2] - d[3]) / 4);
                term[2] = sat_s32(((d[0] - d[1] + d[2] - d[3]) * 65536) / (4 * k));
                for (int c = 0; c < 3; c++)
                begin
                    pose[c] = sat_s32(pose[c] + term[c]);
                    rate[c] = sat_s32((term[c] * 1000000) / dt);
                end
                last_stamp = longint'(it.stamp);
                w = window_size();
                p = (hist_ptr >= w) ? 0 : hist_ptr;
                for (int c = 0; c < 3; c++)
                begin
                    if (hist_fill >= w)
                        rate_total[c] -= rate_hist[c][p];
                    rate_hist[c][p] = rate[c];
                    rate_total[c] += rate[c];
                end
                if (hist_fill < w)
                    hist_fill++;
                hist_ptr = (p + 1 >= w) ? 0 : p + 1;
                r.accepted = 1'b1;
            end
        end
        else if (it.act == ACT_INIT)
        begin
            last_stamp = longint'(it.stamp);
            clear_rate_means();
            r.accepted = 1'b1;
        end
        else if (it.act == ACT_ZERO)
        begin
            for (int c = 0; c < 3; c++)
                pose[c] = 0;
            r.accepted = 1'b1;
        end
        for (int c = 0; c < 3; c++)
        begin
            r.val[c] = pose[c][31:0];
            r.val[3 + c] = (hist_fill == 0) ? 32'd0 : 32'(sat_s32(rate_total[c] / hist_fill));
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d got %0d", name, $signed(exp_v), $signed(act_v));
            error_count++;
        end
    endtask

    // predictor and result checker share one process
    always @(posedge clk)
    begin
        odo_item_t   it;
        odo_result_t r, e;
        upd_taken <= upd.valid && upd.ready;
        res_taken <= res.valid && res.ready;
        if (rst_n && upd.valid && upd.ready)
        begin
            it.act = action_t'(upd.action);
            it.pos[0] = upd.front_left_pos;
            it.pos[1] = upd.front_right_pos;
            it.pos[2] = upd.back_left_pos;
            it.pos[3] = upd.back_right_pos;
            it.stamp = upd.stamp_us;
            predict_odometry(it, r);
            expected_odo.push_back(r);
        end
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_odo.size() == 0)
            begin
                $error("result item with no expectation waiting");
                error_count++;
            end
            else
            begin
                e = expected_odo.pop_front();
                check_field("accepted", 32'(e.accepted), 32'(res.accepted));
                check_field("pose_x", e.val[0], res.pose_x);
                check_field("pose_y", e.val[1], res.pose_y);
                check_field("pose_heading", e.val[2], res.pose_heading);
                check_field("mean_vel_x", e.val[3], res.mean_vel_x);
                check_field("mean_vel_y", e.val[4], res.mean_vel_y);
                check_field("mean_turn_rate", e.val[5], res.mean_turn_rate);
            end
        end
    end

    // sender
    always @(negedge clk)
    begin
        odo_item_t it;
        if (rst_n && (!upd.valid || upd_taken))
        begin
            if (upd_gap > 0)
            begin
                upd_gap--;
                upd.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                upd.action <= it.act;
                upd.front_left_pos <= it.pos[0];
                upd.front_right_pos <= it.pos[1];
                upd.back_left_pos <= it.pos[2];
                upd.back_right_pos <= it.pos[3];
                upd.stamp_us <= it.stamp;
                upd.valid <= 1'b1;
                upd_gap = no_idle ? 0 : $urandom_range(0, 12);
            end
            else
                upd.valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
                res_wait = no_idle ? 0 : $urandom_range(0, 12);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_cnt = 3000;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                res.ready <= 1'b0;
            end
            else if (res_wait > 0)
            begin
                res_wait--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    task automatic add_item(action_t act, logic [47:0] stamp);
        odo_item_t it;
        it.act = act;
        it.pos = gen_pos;
        it.stamp = stamp;
        pending_items.push_back(it);
    endtask

    task automatic add_update(int dt_lo, int dt_hi);
        gen_stamp = gen_stamp + 48'($urandom_range(dt_lo, dt_hi));
        add_item(ACT_UPDATE, gen_stamp);
    endtask

    task automatic add_random_items(int n);
        int pick;
        for (int j = 0; j < n; j++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
            begin
                for (int i = 0; i < 4; i++)
                    gen_pos[i] = gen_pos[i] + 32'($signed($urandom_range(0, 2097152)) - 1048576);
                add_update(MIN_GAP, 3000);
            end
            else if (pick < 70)
            begin
                for (int i = 0; i < 4; i++)
                    gen_pos[i] = $urandom;
                add_update(MIN_GAP, 5000);
            end
            else if (pick < 75)
            begin
                for (int i = 0; i < 4; i++)
                    gen_pos[i] = gen_pos[i] + 32'($urandom_range(0, 65535));
                add_update(MIN_GAP, 16777215);
            end
            else if (pick < 81)
            begin
                gen_pos[$urandom_range(0, 3)] = $urandom;
                add_update(0, MIN_GAP - 1);
            end
            else if (pick < 84)
                add_item(ACT_UPDATE, gen_stamp - 48'($urandom_range(1, 100000)));
            else if (pick < 90)
            begin
                if ($urandom_range(0, 3) == 0)
                    gen_stamp = {16'($urandom), 32'($urandom)};
                else
                    gen_stamp = gen_stamp + 48'($urandom_range(0, 500));
                add_item(ACT_INIT, gen_stamp);
            end
            else if (pick < 95)
                add_item(ACT_ZERO, {16'($urandom), 32'($urandom)});
            else
                add_item(ACT_NONE, {16'($urandom), 32'($urandom)});
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_odo.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_SEP)
            sep_reg = longint'(value);
        else if (idx == CFG_WIN)
        begin
            win_reg = longint'(value[WIN_W-1:0]);
            clear_rate_means();
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [30:0] sep_set [6];
        logic [30:0] win_set [6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        upd.valid = 1'b0;
        upd.action = ACT_UPDATE;
        upd.front_left_pos = '0;
        upd.front_right_pos = '0;
        upd.back_left_pos = '0;
        upd.back_right_pos = '0;
        upd.stamp_us = '0;
        res.ready = 1'b0;
        upd_gap = 0;
        res_wait = 0;
        hold_cnt = 0;
        no_idle = 1'b0;
        sep_reg = 65536;
        win_reg = 10;
        last_stamp = 0;
        for (int i = 0; i < 4; i++)
        begin
            last_pos[i] = 0;
            gen_pos[i] = '0;
        end
        for (int c = 0; c < 3; c++)
            pose[c] = 0;
        clear_rate_means();
        gen_stamp = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every action, short and backward intervals
        add_item(ACT_INIT, 48'd0);
        gen_pos = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
        add_update(MIN_GAP, MIN_GAP);
        gen_pos = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        add_update(MIN_GAP, MIN_GAP);
        gen_pos = '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF};
        add_update(1000, 1000);
        gen_pos = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
        add_update(MIN_GAP, MIN_GAP);
        gen_pos = '{32'h0, 32'h0, 32'h0, 32'h0};
        add_update(MIN_GAP - 1, MIN_GAP - 1);
        add_update(0, 0);
        add_item(ACT_UPDATE, gen_stamp - 48'd1);
        add_update(MIN_GAP, MIN_GAP);
        add_item(ACT_NONE, 48'hFFFFFFFFFFFF);
        add_item(ACT_ZERO, 48'hFFFFFFFFFFFF);
        add_item(ACT_INIT, 48'hFFFFFFFFFF00);
        add_item(ACT_UPDATE, 48'hFFFFFFFFFFFF);
        gen_stamp = 48'd500;
        add_item(ACT_INIT, gen_stamp);
        gen_pos = '{32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000};
        add_update(MIN_GAP, MIN_GAP);
        add_update(0, 1);
        add_random_items(180);
        wait_idle();

        sep_set = '{31'd1, 31'd0, 31'h7FFFFFFF, 31'd0, 31'd0, 31'd98304};
        win_set = '{31'd1, 31'd0, 31'd64, 31'd100, 31'd0, 31'd10};
        sep_set[3] = 31'($urandom);
        sep_set[4] = 31'($urandom_range(1, 1 << 20));
        win_set[4] = 31'($urandom_range(2, 63));
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_SEP, sep_set[ph]);
            write_reg(CFG_WIN, win_set[ph]);
            no_idle = (ph == 1);
            if (ph == 2)
                hold_requests++;
            add_random_items(170);
            wait_idle();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(60_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mwo_pkg.sv
rtl/core/mwo_if.sv
rtl/core/mwo_ram.sv
rtl/core/mwo_div.sv
rtl/core/mwo_dp.sv
rtl/core/mwo_ctrl.sv
rtl/core/mecanum_wheel_odometry.sv
tb/sv/mecanum_wheel_odometry_tb.sv
